// File: src/svs_pkg.sv
package svs_pkg;

  // Brick geometry: 16 voxels per edge, 4096 voxels, 128 occupancy words of 32 bits.
  localparam int BRICK_POS_LSB = 4;
  localparam int WORD_SEL_W = 7;
  localparam int VOX_SEL_W = 12;
  localparam int BIT_SEL_W = 5;
  localparam int OCC_WORD_W = 32;
  localparam int COORD_W = 9;
  localparam int PAL_W = 8;
  localparam int GRID_REG_W = 5;
  localparam int TOTAL_W = 19;
  localparam int BIDX_OUT_W = 6;

  typedef enum logic [1:0] {
    ACT_SET         = 2'd0,
    ACT_TEST        = 2'd1,
    ACT_CLEAR       = 2'd2,
    ACT_RESET_DIRTY = 2'd3
  } action_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [1:0] CFG_BRICKS_X = 2'd0;
  localparam logic [1:0] CFG_BRICKS_Y = 2'd1;
  localparam logic [1:0] CFG_BRICKS_Z = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL1,
    ST_MUL2,
    ST_DIR,
    ST_LOOK,
    ST_CLR,
    ST_OCC,
    ST_UPD,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic dir_re;
    logic dir_we;
    logic rev_re;
    logic rev_we;
    logic occ_re;
    logic occ_we;
    logic pal_we;
  } mem_ctrl_t;

endpackage

// File: src/svs_mac.sv
module svs_mac #(
  parameter int A_W = 12,
  parameter int B_W = 5
) (
  input  logic           clk,
  input  logic           en,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  input  logic [A_W-1:0] c,
  output logic [A_W-1:0] q
);

  logic [A_W+B_W-1:0] prod;
  logic [A_W+B_W-1:0] sum;

  assign prod = (A_W+B_W)'(a) * (A_W+B_W)'(b);
  assign sum  = prod + (A_W+B_W)'(c);

  // Callers guarantee the result fits in A_W bits.
  always_ff @(posedge clk) begin
    if (en) begin
      q <= A_W'(sum);
    end
  end

endmodule

// File: src/svs_mem.sv
module svs_mem #(
  parameter int MAX_BRICKS = 64,
  parameter int MAX_GRID_BRICKS = 16,
  localparam int DIR_DEPTH = MAX_GRID_BRICKS * MAX_GRID_BRICKS * MAX_GRID_BRICKS,
  localparam int DIR_AW = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1,
  localparam int BI_W = (MAX_BRICKS > 1) ? $clog2(MAX_BRICKS) : 1
) (
  input  logic                  clk,
  input  svs_pkg::mem_ctrl_t    ctrl,
  input  logic [DIR_AW-1:0]     dir_addr,
  input  logic [BI_W-1:0]       dir_wdata,
  output logic [BI_W-1:0]       dir_rdata,
  input  logic [BI_W-1:0]       rev_raddr,
  input  logic [BI_W-1:0]       rev_waddr,
  input  logic [DIR_AW-1:0]     rev_wdata,
  output logic [DIR_AW-1:0]     rev_rdata,
  input  logic [BI_W+6:0]       occ_addr,
  input  logic [31:0]           occ_wdata,
  output logic [31:0]           occ_rdata,
  input  logic [BI_W+11:0]      pal_addr,
  input  logic [7:0]            pal_wdata
);

  localparam int OCC_DEPTH = MAX_BRICKS * 128;
  localparam int PAL_DEPTH = MAX_BRICKS * 4096;

  // Directory entries and reverse map are never cleared: an entry counts only
  // when the brick it names is allocated and that brick points back to it.
  logic [BI_W-1:0]   dir_mem [DIR_DEPTH];
  logic [DIR_AW-1:0] rev_mem [MAX_BRICKS];
  logic [31:0]       occ_mem [OCC_DEPTH];
  logic [7:0]        pal_mem [PAL_DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.dir_we) begin
      dir_mem[dir_addr] <= dir_wdata;
    end
    if (ctrl.dir_re) begin
      dir_rdata <= dir_mem[dir_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rev_we) begin
      rev_mem[rev_waddr] <= rev_wdata;
    end
    if (ctrl.rev_re) begin
      rev_rdata <= rev_mem[rev_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.occ_we) begin
      occ_mem[occ_addr] <= occ_wdata;
    end
    if (ctrl.occ_re) begin
      occ_rdata <= occ_mem[occ_addr];
    end
  end

  // Material bytes are stored for the voxel owner; nothing in this block reads them.
  always_ff @(posedge clk) begin
    if (ctrl.pal_we) begin
      pal_mem[pal_addr] <= pal_wdata;
    end
  end

endmodule

// File: src/sparse_brick_voxel_store.sv
// Channel  Direction  Transfer when          Payload
// s_*      in         s_tvalid & s_tready    tuser: action; tdata: x, y, z, palette
// m_*      out        m_tvalid & m_tready    tdata: status .. occupied_total
// cfg_*    in         cfg_valid & cfg_ready  cfg_index selects the grid register
//
// One item at a time; s_tready is high only while the sequencer is idle.
// A hit runs two multiply-add passes for the directory address, directory and reverse-map
// reads, and an occupancy read-modify-write. A miss or a full pool ends after the lookup;
// an allocation first zeroes the brick's 128 words. Out-of-range items end at the range
// check and dirty resets go straight to the result. rst is synchronous; the next item
// is taken while a result waits on m_tready, and the sequencer then holds in its final state.
module sparse_brick_voxel_store #(
  parameter int MAX_BRICKS = 64,
  parameter int MAX_GRID_BRICKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // coord_x, coord_y, coord_z, palette_index, zero fill
  input  logic [1:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // status, solid, removed, brick_index, newly_dirty,
                                 // occupied_total, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  import svs_pkg::*;

  localparam int DIR_DEPTH = MAX_GRID_BRICKS * MAX_GRID_BRICKS * MAX_GRID_BRICKS;
  localparam int DIR_AW = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1;
  localparam int DIM_W = $clog2(MAX_GRID_BRICKS + 1);
  localparam int CMP_W = (DIM_W > GRID_REG_W) ? DIM_W : GRID_REG_W;
  localparam int BI_W = (MAX_BRICKS > 1) ? $clog2(MAX_BRICKS) : 1;
  localparam int NF_W = $clog2(MAX_BRICKS + 1);
  localparam int CNT_RAW_W = $clog2(MAX_BRICKS * 4096 + 1);
  localparam int CNT_W = (CNT_RAW_W > TOTAL_W) ? CNT_RAW_W : TOTAL_W;
  localparam int BIX_W = (BI_W > BIDX_OUT_W) ? BI_W : BIDX_OUT_W;

  seq_state_t state, state_next;

  logic [GRID_REG_W-1:0] reg_x, reg_y, reg_z;
  logic [CMP_W-1:0]      dim_x, dim_y, dim_z;

  action_t            act;
  logic signed [8:0]  cx, cy, cz;
  logic [7:0]         pal;

  logic [1:0]         res_status;
  logic               res_solid;
  logic               res_removed;
  logic               res_newly;
  logic [BI_W-1:0]    bi;
  logic [NF_W-1:0]    nf;
  logic [CNT_W-1:0]   cnt;
  logic [MAX_BRICKS-1:0] dirty;
  logic [WORD_SEL_W-1:0] clr_cnt;

  logic [3:0]            bx, by, bz;
  logic                  in_range;
  logic [WORD_SEL_W-1:0] word_sel;
  logic [BIT_SEL_W-1:0]  bit_sel;
  logic [VOX_SEL_W-1:0]  vox_sel;

  logic              mac_en;
  logic [DIR_AW-1:0] mac_a, mac_c, mac_q;
  logic [DIM_W-1:0]  mac_b;

  mem_ctrl_t         mem_ctrl;
  logic [BI_W-1:0]   dir_rdata;
  logic [DIR_AW-1:0] rev_rdata;
  logic [31:0]       occ_wdata, occ_rdata;
  logic [BI_W+6:0]   occ_addr;

  logic hit, pool_full, solid_now;
  logic [BIX_W-1:0] bi_ext;

  function automatic logic [CMP_W-1:0] sat_dim(input logic [GRID_REG_W-1:0] r);
    logic [CMP_W-1:0] re;
    re = CMP_W'(r);
    return (re > CMP_W'(MAX_GRID_BRICKS)) ? CMP_W'(MAX_GRID_BRICKS) : re;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_x <= GRID_REG_W'(1);
      reg_y <= GRID_REG_W'(1);
      reg_z <= GRID_REG_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BRICKS_X: reg_x <= cfg_data;
        CFG_BRICKS_Y: reg_y <= cfg_data;
        CFG_BRICKS_Z: reg_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dim_x = sat_dim(reg_x);
  assign dim_y = sat_dim(reg_y);
  assign dim_z = sat_dim(reg_z);

  assign bx = cx[7:4];
  assign by = cy[7:4];
  assign bz = cz[7:4];
  assign in_range = !cx[8] && !cy[8] && !cz[8] &&
                    (CMP_W'(bx) < dim_x) && (CMP_W'(by) < dim_y) && (CMP_W'(bz) < dim_z);
  assign word_sel = {cz[3:0], cy[3:1]};
  assign bit_sel  = {cy[0], cx[3:0]};
  assign vox_sel  = {cz[3:0], cy[3:0], cx[3:0]};

  // A directory entry is live only if its brick is allocated and maps back here.
  assign hit = ({{(NF_W - BI_W + 1){1'b0}}, dir_rdata} < (NF_W + 1)'(nf)) &&
               (rev_rdata == mac_q);
  assign pool_full = (nf >= NF_W'(MAX_BRICKS));
  assign solid_now = occ_rdata[bit_sel];

  svs_mac #(.A_W(DIR_AW), .B_W(DIM_W)) u_mac (
    .clk (clk),
    .en  (mac_en),
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .q   (mac_q)
  );

  svs_mem #(.MAX_BRICKS(MAX_BRICKS), .MAX_GRID_BRICKS(MAX_GRID_BRICKS)) u_mem (
    .clk       (clk),
    .ctrl      (mem_ctrl),
    .dir_addr  (mac_q),
    .dir_wdata (BI_W'(nf)),
    .dir_rdata (dir_rdata),
    .rev_raddr (dir_rdata),
    .rev_waddr (BI_W'(nf)),
    .rev_wdata (mac_q),
    .rev_rdata (rev_rdata),
    .occ_addr  (occ_addr),
    .occ_wdata (occ_wdata),
    .occ_rdata (occ_rdata),
    .pal_addr  ({bi, vox_sel}),
    .pal_wdata (pal)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mac_en     = 1'b0;
    mac_a      = DIR_AW'(bz);
    mac_b      = DIM_W'(dim_y);
    mac_c      = DIR_AW'(by);
    mem_ctrl   = '0;
    occ_addr   = {bi, word_sel};
    occ_wdata  = occ_rdata;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (action_t'(s_tuser) == ACT_RESET_DIRTY) ? ST_DONE : ST_CHECK;
        end
      end
      ST_CHECK: begin
        mac_en = 1'b1;
        state_next = in_range ? ST_MUL1 : ST_DONE;
      end
      ST_MUL1: begin
        mac_en = 1'b1;
        mac_a  = mac_q;
        mac_b  = DIM_W'(dim_x);
        mac_c  = DIR_AW'(bx);
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        mem_ctrl.dir_re = 1'b1;
        state_next = ST_DIR;
      end
      ST_DIR: begin
        mem_ctrl.rev_re = 1'b1;
        state_next = ST_LOOK;
      end
      ST_LOOK: begin
        if (hit) begin
          state_next = ST_OCC;
        end else if (act == ACT_SET && !pool_full) begin
          mem_ctrl.dir_we = 1'b1;
          mem_ctrl.rev_we = 1'b1;
          state_next = ST_CLR;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_CLR: begin
        mem_ctrl.occ_we = 1'b1;
        occ_addr  = {bi, clr_cnt};
        occ_wdata = '0;
        if (clr_cnt == '1) begin
          state_next = ST_OCC;
        end
      end
      ST_OCC: begin
        mem_ctrl.occ_re = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (act == ACT_SET) begin
          mem_ctrl.pal_we = 1'b1;
          mem_ctrl.occ_we = !solid_now;
          occ_wdata = occ_rdata | (32'd1 << bit_sel);
        end else if (act == ACT_CLEAR) begin
          mem_ctrl.occ_we = solid_now;
          occ_wdata = occ_rdata & ~(32'd1 << bit_sel);
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Item fields and per-item results.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      act         <= action_t'(s_tuser);
      cx          <= s_tdata[8:0];
      cy          <= s_tdata[17:9];
      cz          <= s_tdata[26:18];
      pal         <= s_tdata[34:27];
      res_status  <= STAT_OK;
      res_solid   <= 1'b0;
      res_removed <= 1'b0;
      res_newly   <= 1'b0;
      bi          <= '0;
    end
    if (state == ST_CHECK && !in_range) begin
      res_status <= STAT_RANGE;
    end
    if (state == ST_LOOK) begin
      clr_cnt <= '0;
      if (hit) begin
        bi <= dir_rdata;
      end else if (act == ACT_SET) begin
        if (pool_full) begin
          res_status <= STAT_FULL;
        end else begin
          bi <= BI_W'(nf);
        end
      end
    end
    if (state == ST_CLR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
    if (state == ST_UPD) begin
      res_solid <= solid_now;
      if (act == ACT_CLEAR && solid_now) begin
        res_removed <= 1'b1;
        res_newly   <= !dirty[bi];
      end
    end
  end

  // Allocator, running count, dirty marks and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      nf       <= '0;
      cnt      <= '0;
      dirty    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_IDLE && s_tvalid && action_t'(s_tuser) == ACT_RESET_DIRTY) begin
        dirty <= '0;
      end
      if (state == ST_LOOK && !hit && act == ACT_SET && !pool_full) begin
        nf <= nf + 1'b1;
      end
      if (state == ST_UPD) begin
        if (act == ACT_SET && !solid_now) begin
          cnt <= cnt + 1'b1;
        end else if (act == ACT_CLEAR && solid_now) begin
          if (cnt != '0) begin
            cnt <= cnt - 1'b1;
          end
          dirty[bi] <= 1'b1;
        end
      end
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign bi_ext = BIX_W'(bi);

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {2'b00, cnt[TOTAL_W-1:0], res_newly, bi_ext[BIDX_OUT_W-1:0],
                  res_removed, res_solid, res_status};
    end
  end

endmodule

// File: tb/svs_checker.sv
`timescale 1ns / 1ps

module svs_checker #(
  parameter int MAX_BRICKS = 64,
  parameter int MAX_GRID_BRICKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // coord_x, coord_y, coord_z, palette_index, zero fill
  input  logic [1:0]  s_tuser,   // action
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // status, solid, removed, brick_index, newly_dirty,
                                 // occupied_total, zero fill
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output int          errors,
  output int          pending
);

  import svs_pkg::*;

  localparam int BRICK_VOXELS = 1 << VOX_SEL_W;
  localparam int DIR_ENTRIES = MAX_GRID_BRICKS * MAX_GRID_BRICKS * MAX_GRID_BRICKS;
  localparam int REPORT_LIMIT = 10;

  // Members run from the top bit down, so the struct lines up with m_tdata[29:0].
  typedef struct packed {
    logic [TOTAL_W-1:0]    total;
    logic                  dirty_new;
    logic [BIDX_OUT_W-1:0] brick;
    logic                  removed;
    logic                  solid;
    logic [1:0]            status;
  } voxel_reply_t;

  logic [GRID_REG_W-1:0] grid_x, grid_y, grid_z;
  bit                    dir_used [DIR_ENTRIES];
  int unsigned           dir_brick [DIR_ENTRIES];
  bit                    occ_map [MAX_BRICKS * BRICK_VOXELS];
  logic [MAX_BRICKS-1:0] dirty;
  int unsigned           next_brick;
  logic [TOTAL_W-1:0]    voxel_count;
  voxel_reply_t          expected_replies [$];
  int                    fail_cnt = 0;

  function automatic int unsigned grid_cap(input logic [GRID_REG_W-1:0] r);
    return (r > MAX_GRID_BRICKS) ? MAX_GRID_BRICKS : r;
  endfunction

  // Palette bytes never reach the result, so they are not tracked here.
  task automatic predict_voxel_action(input action_t act, input logic [COORD_W-1:0] cx,
                                      input logic [COORD_W-1:0] cy,
                                      input logic [COORD_W-1:0] cz,
                                      output voxel_reply_t r);
    int unsigned dx, dy, dz, bx, by, bz, dpos, vox, base, bi;
    bit have;
    r = '0;
    dx = grid_cap(grid_x);
    dy = grid_cap(grid_y);
    dz = grid_cap(grid_z);
    bx = cx[COORD_W-2:BRICK_POS_LSB];
    by = cy[COORD_W-2:BRICK_POS_LSB];
    bz = cz[COORD_W-2:BRICK_POS_LSB];
    if (act == ACT_RESET_DIRTY) begin
      dirty = '0;
    end else if (cx[COORD_W-1] || cy[COORD_W-1] || cz[COORD_W-1] ||
                 bx >= dx || by >= dy || bz >= dz) begin
      r.status = STAT_RANGE;
    end else begin
      dpos = (bz * dy + by) * dx + bx;
      vox = {cz[BRICK_POS_LSB-1:0], cy[BRICK_POS_LSB-1:0], cx[BRICK_POS_LSB-1:0]};
      have = dir_used[dpos];
      bi = have ? dir_brick[dpos] : 0;
      if (act == ACT_SET && !have) begin
        if (next_brick >= MAX_BRICKS) begin
          r.status = STAT_FULL;
        end else begin
          bi = next_brick;
          next_brick++;
          dir_used[dpos] = 1'b1;
          dir_brick[dpos] = bi;
          base = bi * BRICK_VOXELS;
          for (int i = 0; i < BRICK_VOXELS; i++) occ_map[base + i] = 1'b0;
          have = 1'b1;
        end
      end
      if (have) begin
        base = bi * BRICK_VOXELS + vox;
        r.solid = occ_map[base];
        r.brick = bi[BIDX_OUT_W-1:0];
        if (act == ACT_SET) begin
          if (!r.solid) begin
            occ_map[base] = 1'b1;
            voxel_count++;
          end
        end else if (act == ACT_CLEAR && r.solid) begin
          occ_map[base] = 1'b0;
          if (voxel_count != 0) voxel_count--;
          r.removed = 1'b1;
          if (!dirty[bi]) begin
            dirty[bi] = 1'b1;
            r.dirty_new = 1'b1;
          end
        end
      end
    end
    r.total = voxel_count;
  endtask

  always @(posedge clk) begin
    voxel_reply_t want, got;
    if (rst) begin
      grid_x = 5'd1;
      grid_y = 5'd1;
      grid_z = 5'd1;
      foreach (dir_used[i]) dir_used[i] = 1'b0;
      foreach (occ_map[i]) occ_map[i] = 1'b0;
      dirty = '0;
      next_brick = 0;
      voxel_count = '0;
      expected_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BRICKS_X: grid_x = cfg_data;
          CFG_BRICKS_Y: grid_y = cfg_data;
          CFG_BRICKS_Z: grid_z = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        predict_voxel_action(action_t'(s_tuser), s_tdata[COORD_W-1:0],
                             s_tdata[2*COORD_W-1:COORD_W], s_tdata[3*COORD_W-1:2*COORD_W],
                             want);
        expected_replies.insert(expected_replies.size(), want);
      end
      if (m_tvalid && m_tready) begin
        got = voxel_reply_t'(m_tdata[$bits(voxel_reply_t)-1:0]);
        if (expected_replies.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_LIMIT)
            $display("result transfer with no item outstanding: tdata %h", m_tdata);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_LIMIT)
              $display({"result mismatch: expected status %0d solid %0d removed %0d ",
                        "brick %0d newly_dirty %0d total %0d, got status %0d solid %0d ",
                        "removed %0d brick %0d newly_dirty %0d total %0d"},
                       want.status, want.solid, want.removed, want.brick, want.dirty_new,
                       want.total, got.status, got.solid, got.removed, got.brick,
                       got.dirty_new, got.total);
          end
        end
      end
    end
    errors <= fail_cnt;
    pending <= expected_replies.size();
  end

endmodule

// File: tb/tb_sparse_brick_voxel_store.sv
`timescale 1ns / 1ps

module tb_sparse_brick_voxel_store;
  import svs_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int IDLE_PCT = 38;
  localparam int HISTORY_DEPTH = 32;
  localparam int NUM_PHASES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = ACT_TEST;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_BRICKS_X;
  logic [4:0]  cfg_data = '0;
  logic        no_idle = 1'b0;
  int          errors;
  int          pending;

  logic [3*COORD_W-1:0] set_history [$];

  // Grid settings per random phase; 31 and 20 exercise saturation, 0 an empty grid.
  int phase_gx [NUM_PHASES] = '{16, 3, 16, 31, 1, 0, 1, 7};
  int phase_gy [NUM_PHASES] = '{16, 2, 1, 20, 16, 4, 1, 9};
  int phase_gz [NUM_PHASES] = '{16, 5, 1, 16, 1, 4, 1, 16};
  int phase_items [NUM_PHASES] = '{140, 80, 60, 80, 60, 20, 50, 60};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sparse_brick_voxel_store u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  svs_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

  initial begin
    #10_000_000;
    $display("sparse_brick_voxel_store test failed");
    $finish;
  end

  // tvalid is left high after a transfer; it drops between items only for random idle gaps.
  task automatic send_item(input action_t act, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                           input logic [PAL_W-1:0] pal);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {5'b0, pal, z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic program_grid(input logic [4:0] gx, input logic [4:0] gy,
                              input logic [4:0] gz, input bit with_spare);
    logic [4:0] vals [4];
    logic [1:0] idx [4];
    int n;
    vals = '{gx, gy, gz, 5'h15};
    idx = '{CFG_BRICKS_X, CFG_BRICKS_Y, CFG_BRICKS_Z, CFG_SPARE};
    n = with_spare ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] pick_axis(input int g);
    int eff;
    eff = (g > 16) ? 16 : g;
    if (eff == 0) return COORD_W'($urandom);
    return COORD_W'($urandom_range(0, eff * 16 - 1));
  endfunction

  // Most items revisit voxels or bricks that were set recently, so that hits,
  // clears of occupied voxels and dirty marking happen often.
  task automatic random_item(input int gx, input int gy, input int gz);
    action_t act;
    logic [COORD_W-1:0] x, y, z;
    logic [3*COORD_W-1:0] h;
    int a, r;
    a = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    act = (a < 40) ? ACT_SET : (a < 60) ? ACT_TEST : (a < 92) ? ACT_CLEAR : ACT_RESET_DIRTY;
    h = (set_history.size() > 0) ? set_history[$urandom_range(0, set_history.size() - 1)]
                                 : '0;
    if (set_history.size() > 0 && r < 35) begin
      {z, y, x} = h;
    end else if (set_history.size() > 0 && r < 60) begin
      x = {h[COORD_W-1:4], 4'($urandom_range(0, 15))};
      y = {h[2*COORD_W-1:COORD_W+4], 4'($urandom_range(0, 15))};
      z = {h[3*COORD_W-1:2*COORD_W+4], 4'($urandom_range(0, 15))};
    end else if (r < 90) begin
      x = pick_axis(gx);
      y = pick_axis(gy);
      z = pick_axis(gz);
    end else begin
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
      z = COORD_W'($urandom);
    end
    if (act == ACT_SET) begin
      set_history.insert(set_history.size(), {z, y, x});
      if (set_history.size() > HISTORY_DEPTH) void'(set_history.pop_front());
    end
    send_item(act, x, y, z, PAL_W'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset grid of one brick: unallocated brick, allocation, overwrite,
    // clears of full and empty voxels, dirty marking and range checks.
    send_item(ACT_TEST, 9'd0, 9'd0, 9'd0, 8'h00);
    send_item(ACT_CLEAR, 9'd0, 9'd0, 9'd0, 8'hFF);
    send_item(ACT_SET, 9'd0, 9'd0, 9'd0, 8'h00);
    send_item(ACT_SET, 9'd0, 9'd0, 9'd0, 8'hFF);
    send_item(ACT_TEST, 9'd0, 9'd0, 9'd0, 8'h00);
    send_item(ACT_SET, 9'd15, 9'd15, 9'd15, 8'hA5);
    send_item(ACT_CLEAR, 9'd0, 9'd0, 9'd0, 8'h00);
    send_item(ACT_CLEAR, 9'd15, 9'd15, 9'd15, 8'h00);
    send_item(ACT_CLEAR, 9'd15, 9'd15, 9'd15, 8'h00);
    send_item(ACT_RESET_DIRTY, 9'h1FF, 9'h1FF, 9'h1FF, 8'hFF);
    send_item(ACT_SET, 9'd7, 9'd3, 9'd9, 8'h5A);
    send_item(ACT_CLEAR, 9'd7, 9'd3, 9'd9, 8'h00);
    send_item(ACT_SET, 9'd16, 9'd0, 9'd0, 8'h11);
    send_item(ACT_SET, 9'h1FF, 9'd0, 9'd0, 8'h22);
    send_item(ACT_CLEAR, 9'd0, 9'd0, 9'h100, 8'h00);
    send_item(ACT_TEST, 9'd255, 9'd255, 9'd255, 8'h00);

    // A zero grid register leaves no voxel inside the grid.
    wait_drained();
    program_grid(5'd0, 5'd1, 5'd1, 1'b1);
    send_item(ACT_TEST, 9'd0, 9'd0, 9'd0, 8'h00);
    send_item(ACT_SET, 9'd0, 9'd0, 9'd0, 8'h33);

    // Registers above the limit saturate; the old entry keeps directory slot 0.
    wait_drained();
    program_grid(5'd31, 5'd16, 5'd16, 1'b0);
    send_item(ACT_SET, 9'd255, 9'd255, 9'd255, 8'hFF);
    send_item(ACT_TEST, 9'd0, 9'd0, 9'd0, 8'h00);
    send_item(ACT_SET, 9'd16, 9'd0, 9'd0, 8'h44);
    send_item(ACT_SET, 9'd255, 9'd0, 9'd0, 8'h00);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      program_grid(5'(phase_gx[p]), 5'(phase_gy[p]), 5'(phase_gz[p]), 1'b0);
      no_idle <= (p == 2);
      for (int n = 0; n < phase_items[p]; n++)
        random_item(phase_gx[p], phase_gy[p], phase_gz[p]);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("sparse_brick_voxel_store test passed");
    end else begin
      $display("sparse_brick_voxel_store test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/svs_pkg.sv
src/svs_mac.sv
src/svs_mem.sv
src/sparse_brick_voxel_store.sv
tb/svs_checker.sv
tb/tb_sparse_brick_voxel_store.sv
